[rtl/bf_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blowfish engine package
// Shared constants, opcode and state types, and the S-box write request.
// ----------------------------------------------------------------------------
package bf_pkg;

	// Cipher geometry.
	localparam int ROUNDS      = 16;
	localparam int KEY_BYTES   = 16;
	localparam int WORD_W      = 32;
	localparam int P_WORDS     = ROUNDS + 2;
	localparam int BOX_WORDS   = 256;
	localparam int S_WORDS     = 4 * BOX_WORDS;
	localparam int TABLE_WORDS = P_WORDS + S_WORDS;
	localparam int IDX_W       = 11;
	localparam int S_ADDR_W    = 10;
	localparam int P_ADDR_W    = 5;
	localparam int RND_W       = 4;

	// Configuration register indexes.
	localparam logic REG_KEY_HIGH = 1'b0;
	localparam logic REG_KEY_LOW  = 1'b1;

	// Item opcodes.
	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_EXPAND  = 2'd1,
		OP_ENCRYPT = 2'd2,
		OP_DECRYPT = 2'd3
	} op_t;

	// Sequencer states.
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_KEYXOR,
		ST_START,
		ST_ISSUE,
		ST_UPDATE,
		ST_FINAL,
		ST_STORE_L,
		ST_STORE_R,
		ST_DONE
	} state_t;

	// One write into the S-box memories.
	typedef struct packed {
		logic                en;
		logic [S_ADDR_W-1:0] addr;
		logic [WORD_W-1:0]   data;
	} sbox_wr_t;

endpackage

[rtl/bf_sbox_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blowfish S-box RAM
// One 256 x 32 box with a single write port and a registered read port.
// ----------------------------------------------------------------------------
module bf_sbox_ram (
	input  logic        clk,
	input  logic        we,
	input  logic [7:0]  waddr,
	input  logic [31:0] wdata,
	input  logic [7:0]  raddr,
	output logic [31:0] rdata
);
	import bf_pkg::*;

	logic [WORD_W-1:0] mem [BOX_WORDS];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

[rtl/bf_feistel.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blowfish round function unit
// Holds the four S-boxes, looks up the four bytes of the round word and
// combines the registered lookups into F on the following cycle.
// ----------------------------------------------------------------------------
module bf_feistel (
	input  logic             clk,
	input  bf_pkg::sbox_wr_t wr,
	input  logic [31:0]      x,
	output logic [31:0]      f
);
	import bf_pkg::*;

	logic [WORD_W-1:0] rd [4];

	// Box g is indexed by byte g of the word, most significant byte first.
	for (genvar g = 0; g < 4; g++) begin : g_box
		bf_sbox_ram u_ram (
			.clk   (clk),
			.we    (wr.en && (wr.addr[S_ADDR_W-1 -: 2] == 2'(g))),
			.waddr (wr.addr[7:0]),
			.wdata (wr.data),
			.raddr (x[WORD_W-1-8*g -: 8]),
			.rdata (rd[g])
		);
	end

	// F = ((S0 + S1) xor S2) + S3, all modulo 2^32.
	assign f = ((rd[0] + rd[1]) ^ rd[2]) + rd[3];

endmodule

[rtl/blowfish_block_cipher.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blowfish block cipher engine
// Sequenced 16-round Blowfish with a loadable P/S table and key expansion.
// ----------------------------------------------------------------------------
// An encrypt or decrypt item runs from its input transfer through a step of
// input whitening, an issue and an update step for each of the 16 rounds
// (the S-box read is registered, then F is formed and folded in), a step of
// output whitening and a step that posts the result to the output register.
// A load item writes its table word and then posts a zero result. An expand
// item mixes the key into the 18 P words, then runs 521 chained encryptions,
// each followed by a left and a right store step through the single
// table write port. One item is in work at a time; the next input
// transfer is taken once the sequencer is idle again, even while a result
// still waits in the output register. Table words must be written by load
// items before they are used; there is no clearing pass.
// ----------------------------------------------------------------------------
module blowfish_block_cipher #(
	parameter int KEY_BYTES = bf_pkg::KEY_BYTES
) (
	input  logic        clk,
	input  logic        arst_n,
	// Input channel.
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  opcode,
	input  logic [10:0] table_index,
	input  logic [31:0] table_word,
	input  logic [31:0] block_left,
	input  logic [31:0] block_right,
	input  logic        last_block,
	// Output channel.
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] out_left,
	output logic [31:0] out_right,
	output logic        last_out,
	// Configuration port.
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [63:0] cfg_data
);
	import bf_pkg::*;

	localparam int KPW = (KEY_BYTES > 1) ? $clog2(KEY_BYTES) : 1;

	// Key registers.
	logic [63:0] key_high_q, key_low_q;

	// Sequencer and datapath registers.
	state_t              state_q, state_d;
	logic [WORD_W-1:0]   l_q, r_q;
	logic [RND_W-1:0]    rnd_q;
	logic [P_ADDR_W-1:0] xcnt_q;
	logic [IDX_W-1:0]    wcnt_q;
	logic [KPW-1:0]      kpos_q;
	logic                dec_q, blk_q, last_q;
	logic                out_valid_q;
	logic [WORD_W-1:0]   out_left_q, out_right_q;
	logic                out_last_q;

	// P array in flip-flops: one read address and one write per cycle.
	logic [WORD_W-1:0]   p_q [P_WORDS];
	logic [P_ADDR_W-1:0] p_ra, p_n;
	logic [WORD_W-1:0]   p_rd;

	// Unified table write port.
	logic              tw_en;
	logic [IDX_W-1:0]  tw_addr;
	logic [WORD_W-1:0] tw_data;
	sbox_wr_t          s_wr;
	logic [IDX_W-1:0]  s_off;

	logic              in_xfer, out_load;
	logic [WORD_W-1:0] f_val, key_word;
	logic [KPW-1:0]    kp [5];
	logic [127:0]      key_all;

	assign in_xfer  = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || !out_stall);

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_high_q <= '0;
			key_low_q  <= '0;
		end else if (cfg_we) begin
			if (cfg_index == REG_KEY_HIGH) begin
				key_high_q <= cfg_data;
			end else begin
				key_low_q <= cfg_data;
			end
		end
	end

	// Four key bytes per word, position cycling over the used key length.
	assign key_all = {key_high_q, key_low_q};
	always_comb begin
		kp[0]    = kpos_q;
		key_word = '0;
		for (int n = 0; n < 4; n++) begin
			key_word = {key_word[WORD_W-9:0],
				key_all[{4'd15 - 4'(kp[n]), 3'b000} +: 8]};
			kp[n+1] = (kp[n] == KPW'(KEY_BYTES - 1)) ? '0 : kp[n] + 1'b1;
		end
	end

	// P read address: the key-mixing count during key mixing, else the round step number, mirrored for decryption.
	always_comb begin
		case (state_q)
			ST_START:  p_n = '0;
			ST_FINAL:  p_n = P_ADDR_W'(P_WORDS - 1);
			default:   p_n = P_ADDR_W'(rnd_q) + 1'b1;
		endcase
		if (state_q == ST_KEYXOR) begin
			p_ra = xcnt_q;
		end else if (dec_q) begin
			p_ra = P_ADDR_W'(P_WORDS - 1) - p_n;
		end else begin
			p_ra = p_n;
		end
	end
	assign p_rd = (p_ra < P_ADDR_W'(P_WORDS)) ? p_q[p_ra] : '0;

	// Table write source selection.
	always_comb begin
		tw_en   = 1'b0;
		tw_addr = wcnt_q;
		tw_data = l_q;
		case (state_q)
			ST_IDLE: begin
				tw_en   = in_xfer && (op_t'(opcode) == OP_LOAD);
				tw_addr = table_index;
				tw_data = table_word;
			end
			ST_KEYXOR: begin
				tw_en   = 1'b1;
				tw_addr = IDX_W'(xcnt_q);
				tw_data = p_rd ^ key_word;
			end
			ST_STORE_L: begin
				tw_en = 1'b1;
			end
			ST_STORE_R: begin
				tw_en   = 1'b1;
				tw_data = r_q;
			end
			default: begin
				tw_en = 1'b0;
			end
		endcase
	end

	// Decode the table write into P or S.
	assign s_off     = tw_addr - IDX_W'(P_WORDS);
	assign s_wr.en   = tw_en && (tw_addr >= IDX_W'(P_WORDS))
		&& (tw_addr < IDX_W'(TABLE_WORDS));
	assign s_wr.addr = s_off[S_ADDR_W-1:0];
	assign s_wr.data = tw_data;

	always_ff @(posedge clk) begin
		if (tw_en && (tw_addr < IDX_W'(P_WORDS))) begin
			p_q[tw_addr[P_ADDR_W-1:0]] <= tw_data;
		end
	end

	// Shared round function.
	bf_feistel u_feistel (
		.clk (clk),
		.wr  (s_wr),
		.x   (l_q),
		.f   (f_val)
	);

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					case (op_t'(opcode))
						OP_LOAD:   state_d = ST_DONE;
						OP_EXPAND: state_d = ST_KEYXOR;
						default:   state_d = ST_START;
					endcase
				end
			end
			ST_KEYXOR: begin
				if (xcnt_q == P_ADDR_W'(P_WORDS - 1)) begin
					state_d = ST_START;
				end
			end
			ST_START:  state_d = ST_ISSUE;
			ST_ISSUE:  state_d = ST_UPDATE;
			ST_UPDATE: begin
				state_d = (rnd_q == RND_W'(ROUNDS - 1)) ? ST_FINAL : ST_ISSUE;
			end
			ST_FINAL:   state_d = blk_q ? ST_DONE : ST_STORE_L;
			ST_STORE_L: state_d = ST_STORE_R;
			ST_STORE_R: begin
				state_d = (wcnt_q == IDX_W'(TABLE_WORDS - 1)) ? ST_DONE : ST_START;
			end
			ST_DONE: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Datapath registers.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) begin
					l_q    <= block_left;
					r_q    <= block_right;
					rnd_q  <= '0;
					xcnt_q <= '0;
					wcnt_q <= '0;
					kpos_q <= '0;
					dec_q  <= (op_t'(opcode) == OP_DECRYPT);
					blk_q  <= (op_t'(opcode) == OP_ENCRYPT)
						|| (op_t'(opcode) == OP_DECRYPT);
					last_q <= last_block;
				end
			end
			ST_KEYXOR: begin
				xcnt_q <= xcnt_q + 1'b1;
				kpos_q <= kp[4];
				l_q    <= '0;
				r_q    <= '0;
			end
			ST_START: begin
				l_q   <= l_q ^ p_rd;
				rnd_q <= '0;
			end
			ST_UPDATE: begin
				l_q   <= r_q ^ f_val ^ p_rd;
				r_q   <= l_q;
				rnd_q <= rnd_q + 1'b1;
			end
			ST_FINAL: begin
				l_q <= r_q ^ p_rd;
				r_q <= l_q;
			end
			ST_STORE_L, ST_STORE_R: begin
				wcnt_q <= wcnt_q + 1'b1;
			end
			default: begin
				rnd_q <= rnd_q;
			end
		endcase
	end

	// Output register: refilled when the previous result has been taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_left_q  <= blk_q ? l_q : '0;
			out_right_q <= blk_q ? r_q : '0;
			out_last_q  <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_left  = out_left_q;
	assign out_right = out_right_q;
	assign last_out  = out_last_q;

	// An accepted item keeps the input side closed on the next cycle.
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer |=> in_stall)
		else $error("input not stalled after a transfer");

	// Output whitening follows only the last round.
	a_final_after_last_round: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FINAL) |-> ($past(state_q) == ST_UPDATE)
			&& ($past(rnd_q) == RND_W'(ROUNDS - 1)))
		else $error("final step entered before the last round");

	// Expansion stores never run past the end of the table.
	a_store_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_STORE_L) || (state_q == ST_STORE_R))
			|-> (wcnt_q < IDX_W'(TABLE_WORDS)))
		else $error("expansion store beyond the table");

	// A result is posted only when the output register is free or draining.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !out_load)
		else $error("pending result overwritten");

endmodule

[verif/blowfish_block_cipher_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Blowfish block cipher engine testbench
// Runs a directed table of table loads, encryptions, decryptions and key
// expansions, filling the whole P/S table partway, then randomised phases
// under fresh keys. Results are checked against typed values or a behavioural
// predictor; outside one calm phase both channels see random idle and stall.
// ----------------------------------------------------------------------------
module blowfish_block_cipher_tb;

	import bf_pkg::*;

	// Cycles without any transfer before the run is abandoned.
	localparam int QUIET_LIMIT   = 100000;
	localparam int PHASE_ITEMS   = 9;
	localparam int PHASES        = 4;
	localparam int DRAIN_CYCLES  = 60;
	localparam int REPORT_LIMIT  = 10;

	typedef struct {
		op_t         opcode;
		logic [10:0] index;
		logic [31:0] word;
		logic [31:0] left;
		logic [31:0] right;
		logic        last;
	} bf_item_t;

	typedef struct {
		logic [31:0] left;
		logic [31:0] right;
		logic        last;
	} bf_result_t;

	typedef struct {
		bf_item_t   item;
		bit         typed;
		bf_result_t res;
	} bf_row_t;

	logic        clk;
	logic        arst_n      = 1'b0;
	logic        in_valid    = 1'b0;
	logic        in_stall;
	logic [1:0]  opcode      = '0;
	logic [10:0] table_index = '0;
	logic [31:0] table_word  = '0;
	logic [31:0] block_left  = '0;
	logic [31:0] block_right = '0;
	logic        last_block  = 1'b0;
	logic        out_valid;
	logic        out_stall   = 1'b0;
	logic [31:0] out_left;
	logic [31:0] out_right;
	logic        last_out;
	logic        cfg_we      = 1'b0;
	logic        cfg_index   = 1'b0;
	logic [63:0] cfg_data    = '0;

	// Predictor state: its own copy of the tables and the key.
	logic [31:0] p_tab [P_WORDS];
	logic [31:0] s_tab [S_WORDS];
	logic [63:0] key_hi = '0;
	logic [63:0] key_lo = '0;

	bf_result_t expected_blocks [$];
	bf_row_t    directed_rows [$];
	logic [63:0] last_cipher = '0;
	bit          calm = 1'b0;
	int          mismatch_count = 0;
	int          quiet_cycles = 0;

	blowfish_block_cipher DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.opcode      (opcode),
		.table_index (table_index),
		.table_word  (table_word),
		.block_left  (block_left),
		.block_right (block_right),
		.last_block  (last_block),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_left    (out_left),
		.out_right   (out_right),
		.last_out    (last_out),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Blowfish F function over the four S-boxes.
	function automatic logic [31:0] bf_f(logic [31:0] x);
		return ((s_tab[x[31:24]] + s_tab[256 + x[23:16]]) ^ s_tab[512 + x[15:8]])
			+ s_tab[768 + x[7:0]];
	endfunction

	function automatic logic [63:0] bf_encipher(logic [63:0] blk);
		logic [31:0] l = blk[63:32];
		logic [31:0] r = blk[31:0];
		logic [31:0] t;
		for (int i = 0; i < ROUNDS; i++) begin
			l = l ^ p_tab[i];
			r = r ^ bf_f(l);
			t = l; l = r; r = t;
		end
		t = l; l = r; r = t;
		r = r ^ p_tab[ROUNDS];
		l = l ^ p_tab[ROUNDS + 1];
		return {l, r};
	endfunction

	function automatic logic [63:0] bf_decipher(logic [63:0] blk);
		logic [31:0] l = blk[63:32];
		logic [31:0] r = blk[31:0];
		logic [31:0] t;
		for (int i = ROUNDS + 1; i > 1; i--) begin
			l = l ^ p_tab[i];
			r = r ^ bf_f(l);
			t = l; l = r; r = t;
		end
		t = l; l = r; r = t;
		r = r ^ p_tab[1];
		l = l ^ p_tab[0];
		return {l, r};
	endfunction

	// Key schedule: mix the cycled key into P, then overwrite P and S with
	// a chain of encryptions starting from the zero block.
	function automatic void bf_expand();
		logic [127:0] key = {key_hi, key_lo};
		logic [31:0]  k;
		logic [63:0]  blk = '0;
		int           j = 0;
		for (int i = 0; i < P_WORDS; i++) begin
			k = '0;
			for (int n = 0; n < 4; n++) begin
				k = {k[23:0], key[127 - 8 * (j % KEY_BYTES) -: 8]};
				j++;
			end
			p_tab[i] = p_tab[i] ^ k;
		end
		for (int i = 0; i < P_WORDS; i += 2) begin
			blk = bf_encipher(blk);
			p_tab[i]     = blk[63:32];
			p_tab[i + 1] = blk[31:0];
		end
		for (int i = 0; i < S_WORDS; i += 2) begin
			blk = bf_encipher(blk);
			s_tab[i]     = blk[63:32];
			s_tab[i + 1] = blk[31:0];
		end
	endfunction

	// Works out the result of one item and applies its effect on the tables.
	function automatic bf_result_t cipher_predict(bf_item_t it);
		bf_result_t res;
		logic [63:0] blk;
		res.left  = '0;
		res.right = '0;
		res.last  = it.last;
		case (it.opcode)
			OP_LOAD: begin
				if (it.index < P_WORDS)
					p_tab[it.index] = it.word;
				else if (it.index < TABLE_WORDS)
					s_tab[it.index - P_WORDS] = it.word;
			end
			OP_EXPAND: begin
				bf_expand();
			end
			OP_ENCRYPT: begin
				blk = bf_encipher({it.left, it.right});
				res.left  = blk[63:32];
				res.right = blk[31:0];
			end
			default: begin
				blk = bf_decipher({it.left, it.right});
				res.left  = blk[63:32];
				res.right = blk[31:0];
			end
		endcase
		return res;
	endfunction

	// Block data with the extremes turning up often.
	function automatic logic [31:0] rand_word();
		case ($urandom_range(9))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic bf_item_t rand_item();
		bf_item_t it;
		int       pick;
		it.index  = 11'($urandom_range(2047));
		it.word   = $urandom;
		it.left   = rand_word();
		it.right  = rand_word();
		it.last   = 1'($urandom_range(1));
		pick      = $urandom_range(99);
		if (pick < 18) begin
			it.opcode = OP_LOAD;
			if ($urandom_range(99) < 85)
				it.index = 11'($urandom_range(TABLE_WORDS - 1));
			else
				it.index = 11'($urandom_range(2047, TABLE_WORDS));
		end else if (pick < 58) begin
			it.opcode = OP_ENCRYPT;
		end else begin
			it.opcode = OP_DECRYPT;
			// Often take back the most recent ciphertext, as a round trip.
			if ($urandom_range(99) < 40)
				{it.left, it.right} = last_cipher;
		end
		return it;
	endfunction

	function automatic void add_row(op_t op, logic [10:0] idx, logic [31:0] w,
			logic [31:0] l, logic [31:0] r, logic last, bit typed,
			logic [31:0] el, logic [31:0] er, logic elast);
		bf_row_t row;
		row.item.opcode = op;
		row.item.index  = idx;
		row.item.word   = w;
		row.item.left   = l;
		row.item.right  = r;
		row.item.last   = last;
		row.typed       = typed;
		row.res.left    = el;
		row.res.right   = er;
		row.res.last    = elast;
		directed_rows.push_back(row);
	endfunction

	// Presents one item, holds it until its transfer and records the
	// expected result.
	task automatic send_item(input bf_item_t it, input bit typed,
			input bf_result_t typed_res);
		bf_result_t pred;
		@(negedge clk);
		if (!calm && $urandom_range(99) < 8) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(4, 1)) @(negedge clk);
		end
		opcode      <= it.opcode;
		table_index <= it.index;
		table_word  <= it.word;
		block_left  <= it.left;
		block_right <= it.right;
		last_block  <= it.last;
		in_valid    <= 1'b1;
		forever begin
			@(posedge clk);
			if (!in_stall)
				break;
		end
		pred = cipher_predict(it);
		if (it.opcode == OP_ENCRYPT)
			last_cipher = {pred.left, pred.right};
		if (typed)
			expected_blocks.push_back(typed_res);
		else
			expected_blocks.push_back(pred);
	endtask

	task automatic send_random(input bf_item_t it);
		bf_result_t unused;
		unused = '{default: '0};
		send_item(it, 1'b0, unused);
	endtask

	// Drops the input valid and waits until every result has arrived.
	task automatic wait_drained();
		@(negedge clk);
		in_valid <= 1'b0;
		while (expected_blocks.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_key(input logic [63:0] hi, input logic [63:0] lo);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= REG_KEY_HIGH;
		cfg_data  <= hi;
		@(negedge clk);
		cfg_index <= REG_KEY_LOW;
		cfg_data  <= lo;
		key_hi = hi;
		@(negedge clk);
		cfg_we <= 1'b0;
		key_lo = lo;
	endtask

	// Loads every word of the table with random data.
	task automatic fill_table();
		bf_item_t it;
		for (int i = 0; i < TABLE_WORDS; i++) begin
			it.opcode = OP_LOAD;
			it.index  = 11'(i);
			it.word   = $urandom;
			it.left   = $urandom;
			it.right  = $urandom;
			it.last   = 1'($urandom_range(1));
			send_random(it);
		end
	endtask

	// Receiver stall, changed at the falling edge.
	always @(negedge clk) begin
		out_stall <= calm ? 1'b0 : ($urandom_range(99) < 8);
	end

	// Result checker: each output transfer against the oldest expectation.
	always @(posedge clk) begin
		bf_result_t exp_res;
		if (out_valid && !out_stall) begin
			if (expected_blocks.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("unexpected result %h %h %0b", out_left, out_right, last_out);
			end else begin
				exp_res = expected_blocks.pop_front();
				if (out_left !== exp_res.left || out_right !== exp_res.right
						|| last_out !== exp_res.last) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT)
						$display("mismatch: expected %h %h %0b, got %h %h %0b",
							exp_res.left, exp_res.right, exp_res.last,
							out_left, out_right, last_out);
				end
			end
		end
	end

	// Watchdog on cycles without any transfer.
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("blowfish_block_cipher_tb NOT OK");
			$finish;
		end
	end

	initial begin
		bf_item_t it;
		int       fill_row;
		for (int i = 0; i < P_WORDS; i++)
			p_tab[i] = '0;
		for (int i = 0; i < S_WORDS; i++)
			s_tab[i] = '0;

		// Loads return zero blocks; out-of-range loads write nothing.
		add_row(OP_LOAD, 11'd0, 32'h0, 32'h0, 32'h0, 1'b0, 1, 32'h0, 32'h0, 1'b0);
		add_row(OP_LOAD, 11'd17, 32'hFFFF_FFFF, 32'h0, 32'hFFFF_FFFF, 1'b1, 1,
			32'h0, 32'h0, 1'b1);
		add_row(OP_LOAD, 11'd18, 32'h1234_5678, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0, 1,
			32'h0, 32'h0, 1'b0);
		add_row(OP_LOAD, 11'd1041, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 1,
			32'h0, 32'h0, 1'b1);
		add_row(OP_LOAD, 11'd1042, 32'hFFFF_FFFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 1'b0, 1,
			32'h0, 32'h0, 1'b0);
		add_row(OP_LOAD, 11'd2047, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1,
			32'h0, 32'h0, 1'b1);
		fill_row = directed_rows.size();
		// From here on the table is fully written.
		add_row(OP_ENCRYPT, 11'd0, 32'h0, 32'h0, 32'h0, 1'b0, 0, 0, 0, 0);
		add_row(OP_ENCRYPT, 11'd2047, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			0, 0, 0, 0);
		add_row(OP_DECRYPT, 11'd0, 32'h0, 32'h0, 32'h0, 1'b0, 0, 0, 0, 0);
		add_row(OP_DECRYPT, 11'd2047, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1,
			0, 0, 0, 0);
		add_row(OP_ENCRYPT, 11'd5, 32'h0, 32'h0123_4567, 32'h89AB_CDEF, 1'b0, 0, 0, 0, 0);
		add_row(OP_LOAD, 11'd5, 32'hDEAD_BEEF, 32'h0, 32'h0, 1'b0, 0, 0, 0, 0);
		add_row(OP_ENCRYPT, 11'd0, 32'h0, 32'h0123_4567, 32'h89AB_CDEF, 1'b1, 0, 0, 0, 0);
		add_row(OP_EXPAND, 11'd2047, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 1'b1, 0, 0, 0, 0);
		add_row(OP_ENCRYPT, 11'd0, 32'h0, 32'h0, 32'h0, 1'b0, 0, 0, 0, 0);
		// A second expansion works on the tables the first one left.
		add_row(OP_EXPAND, 11'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0, 0, 0, 0, 0);
		add_row(OP_ENCRYPT, 11'd1041, 32'h0, 32'hFFFF_FFFF, 32'h0, 1'b1, 0, 0, 0, 0);
		add_row(OP_DECRYPT, 11'd17, 32'h0, 32'h8000_0000, 32'h0000_0001, 1'b0, 0, 0, 0, 0);
		add_row(OP_LOAD, 11'd1041, 32'h0, 32'h0, 32'h0, 1'b1, 0, 0, 0, 0);
		add_row(OP_DECRYPT, 11'd0, 32'h0, 32'h0, 32'hFFFF_FFFF, 1'b1, 0, 0, 0, 0);

		// Reset, then the first key while the engine is idle.
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_key(64'hFFFF_FFFF_FFFF_FFFF, 64'h0);

		// Directed table.
		for (int i = 0; i < directed_rows.size(); i++) begin
			if (i == fill_row)
				fill_table();
			send_item(directed_rows[i].item, directed_rows[i].typed, directed_rows[i].res);
		end

		// Random phases, each under its own key and opened by an expansion.
		for (int ph = 0; ph < PHASES; ph++) begin
			wait_drained();
			case (ph)
				0: write_key(64'h0, 64'h0);
				1: write_key(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
				default: write_key({$urandom, $urandom}, {$urandom, $urandom});
			endcase
			// One phase runs with neither side idling.
			calm = (ph == 2);
			it = rand_item();
			it.opcode = OP_EXPAND;
			send_random(it);
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_random(rand_item());
		end
		calm = 1'b0;

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0 && expected_blocks.size() == 0)
			$display("blowfish_block_cipher_tb OK");
		else
			$display("blowfish_block_cipher_tb NOT OK");
		$finish;
	end

endmodule
